[sv/sound_level_led_matrix_scanner_defines.svh]
// Assertion macros for the scanner RTL.
// SLMS_ASSERT is checked only out of reset; SLMS_ASSERT_ALWAYS holds at every edge.
`ifndef SOUND_LEVEL_LED_MATRIX_SCANNER_DEFINES_SVH
`define SOUND_LEVEL_LED_MATRIX_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS
`define SLMS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("slms assertion failed");
`define SLMS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("slms assertion failed");
`else
`define SLMS_ASSERT(lbl, clk, rst_n, prop)
`define SLMS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[sv/slms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package slms_pkg;

    // word field widths
    localparam int CMD_W    = 1;
    localparam int SAMPLE_W = 10;
    localparam int COL_W    = 3;
    localparam int ROW_W    = 5;
    localparam int LEVEL_W  = 3;
    localparam int SUM_W    = 13;
    localparam int DIST_W   = 9;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_OVR_ON  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_PATTERN = 2'd2;

    localparam logic [DIST_W-1:0] DEAD_ZONE_RST = 9'd12;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b1;

    localparam logic [SAMPLE_W-1:0] MID_SCALE = 10'd512;
    localparam logic [SUM_W-1:0]    SUM_MAX   = 13'h1FFF;

    // defaults for the top-level parameters
    localparam int SAMPLES_PER_BATCH = 8;
    localparam int NUM_FACES         = 6;
    localparam int LEVEL_SCALE       = 12;

    // stored face bitmaps, one 5-bit row pattern per column
    localparam int TABLE_FACES = 6;
    localparam int NUM_COLS    = 8;
    localparam logic [COL_W-1:0] EYE_COL = 3'd1;
    localparam logic [ROW_W-1:0] FACE_MAP [TABLE_FACES][NUM_COLS] = '{
        '{5'h00, 5'h0A, 5'h00, 5'h0E, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h0A, 5'h00, 5'h0E, 5'h0E, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h0A, 5'h00, 5'h0E, 5'h11, 5'h0E, 5'h00, 5'h00},
        '{5'h00, 5'h0A, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h0E, 5'h00},
        '{5'h00, 5'h0A, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h00, 5'h1B, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E}
    };

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [SAMPLE_W-1:0] sample;
    } t_in_word;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row_drive;
        logic [LEVEL_W-1:0] face_level;
        logic               level_updated;
    } t_out_word;

endpackage

`default_nettype wire

[sv/slms_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface slms_in_if;
    logic                            valid;
    logic                            ready;
    logic [slms_pkg::CMD_W-1:0]      command;
    logic [slms_pkg::SAMPLE_W-1:0]   sample;

    modport source (output valid, output command, output sample, input ready);
    modport sink   (input valid, input command, input sample, output ready);
endinterface

`default_nettype wire

[sv/slms_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface slms_out_if;
    logic                           valid;
    logic                           ready;
    logic [slms_pkg::COL_W-1:0]     column;
    logic [slms_pkg::ROW_W-1:0]     row_drive;
    logic [slms_pkg::LEVEL_W-1:0]   face_level;
    logic                           level_updated;

    modport source (output valid, output column, output row_drive, output face_level,
                    output level_updated, input ready);
    modport sink   (input valid, input column, input row_drive, input face_level,
                    input level_updated, output ready);
endinterface

`default_nettype wire

[sv/sound_level_led_matrix_scanner.sv]
// Sound-level LED matrix scanner. Each input word is either a refresh tick (command 0),
// which steps the driven column 0..7 and wraps, or an audio sample (command 1), whose
// distance from mid-scale 512 outside the dead zone is added to a 13-bit saturating
// sum. Every SAMPLES_PER_BATCH samples the sum is divided by SAMPLES_PER_BATCH and by
// LEVEL_SCALE, clamped to NUM_FACES-1, and becomes the shown face; sum and count are
// then cleared and level_updated is set in that word's result. Every input word gives
// exactly one result word: the driven column, its active-low row bits (column 1 shows
// eye_pattern while eye_override_on is set; faces above the six stored bitmaps show
// the last one), and the current face. Rate: one word per clock while the output
// takes results. A word passes an input register and then a result register; the
// result register lets a new word enter while a finished one waits. Ready follows
// the output side combinationally. Configuration (dead_zone at index 0,
// eye_override_on at 1, eye_pattern at 2) must be written only while idle; the
// block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module sound_level_led_matrix_scanner #(
    parameter int SAMPLES_PER_BATCH = slms_pkg::SAMPLES_PER_BATCH,
    parameter int NUM_FACES         = slms_pkg::NUM_FACES
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [slms_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [slms_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    slms_in_if.sink                                i_in,
    slms_out_if.source                             o_out
);

`include "sound_level_led_matrix_scanner_defines.svh"

    localparam int BCW = (SAMPLES_PER_BATCH > 1) ? $clog2(SAMPLES_PER_BATCH) : 1;
    localparam int FW  = $clog2(NUM_FACES);
    // combined divisor: floor(floor(s/a)/b) == floor(s/(a*b))
    localparam int DIVISOR = SAMPLES_PER_BATCH * slms_pkg::LEVEL_SCALE;
    localparam logic [BCW-1:0] BATCH_LAST = BCW'(SAMPLES_PER_BATCH - 1);
    localparam logic [FW-1:0]  FACE_LAST  = FW'(NUM_FACES - 1);

    // configuration registers
    logic [slms_pkg::DIST_W-1:0] r_dead_zone;
    logic                        r_eye_ovr;
    logic [slms_pkg::ROW_W-1:0]  r_eye_pat;

    // block state
    logic [slms_pkg::COL_W-1:0]  r_col,   n_col;
    logic [FW-1:0]               r_face,  n_face;
    logic [BCW-1:0]              r_batch, n_batch;
    logic [slms_pkg::SUM_W-1:0]  r_sum,   n_sum;

    // pipeline
    logic                  r_s1_valid;
    slms_pkg::t_in_word    r_s1;
    logic                  r_out_valid;
    slms_pkg::t_out_word   r_out, n_out;
    logic                  s1_adv;

    // datapath temporaries; distance reaches 512 below the band with no dead zone
    logic [slms_pkg::SAMPLE_W-1:0] hi_edge, lo_edge;
    logic [slms_pkg::SAMPLE_W-1:0] samp_dist;
    logic [slms_pkg::SUM_W:0]      sum_wide;
    logic [slms_pkg::SUM_W-1:0]    sum_sat;
    logic [FW-1:0]                 batch_level;
    logic                          batch_done;
    logic [2:0]                    face_idx;
    logic [slms_pkg::ROW_W-1:0]    bits;

    // handshake: result register frees up when empty or being taken
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;

    assign o_out.valid         = r_out_valid;
    assign o_out.column        = r_out.column;
    assign o_out.row_drive     = r_out.row_drive;
    assign o_out.face_level    = r_out.face_level;
    assign o_out.level_updated = r_out.level_updated;

    // sample distance outside the quiet band
    always_comb begin
        hi_edge = slms_pkg::MID_SCALE + slms_pkg::SAMPLE_W'(r_dead_zone);
        lo_edge = slms_pkg::MID_SCALE - slms_pkg::SAMPLE_W'(r_dead_zone);
        if (r_s1.sample > hi_edge) begin
            samp_dist = slms_pkg::SAMPLE_W'(r_s1.sample - hi_edge);
        end else if (r_s1.sample < lo_edge) begin
            samp_dist = slms_pkg::SAMPLE_W'(lo_edge - r_s1.sample);
        end else begin
            samp_dist = '0;
        end
        sum_wide = {1'b0, r_sum} + (slms_pkg::SUM_W + 1)'(samp_dist);
        sum_sat  = sum_wide[slms_pkg::SUM_W] ? slms_pkg::SUM_MAX
                                             : sum_wide[slms_pkg::SUM_W-1:0];
    end

    // quotient by threshold compares; the count of met thresholds is already clamped
    always_comb begin
        batch_level = '0;
        for (int k = 1; k < NUM_FACES; k++) begin
            if (int'(sum_sat) >= k * DIVISOR) begin
                batch_level = FW'(k);
            end
        end
    end

    // next state and result
    always_comb begin
        n_col      = r_col;
        n_face     = r_face;
        n_batch    = r_batch;
        n_sum      = r_sum;
        batch_done = 1'b0;
        case (r_s1.command)
            slms_pkg::CMD_TICK: begin
                n_col = r_col + 1'b1;
            end
            slms_pkg::CMD_SAMPLE: begin
                if (r_batch == BATCH_LAST) begin
                    batch_done = 1'b1;
                    n_face     = batch_level;
                    n_batch    = '0;
                    n_sum      = '0;
                end else begin
                    n_batch = r_batch + 1'b1;
                    n_sum   = sum_sat;
                end
            end
            default: begin
                n_col = r_col;
            end
        endcase

        face_idx = (int'(n_face) >= slms_pkg::TABLE_FACES)
                 ? 3'(slms_pkg::TABLE_FACES - 1) : 3'(n_face);
        if (n_col == slms_pkg::EYE_COL && r_eye_ovr) begin
            bits = r_eye_pat;
        end else begin
            bits = slms_pkg::FACE_MAP[face_idx][n_col];
        end

        n_out.column        = n_col;
        n_out.row_drive     = ~bits;
        n_out.face_level    = slms_pkg::LEVEL_W'(n_face);
        n_out.level_updated = batch_done;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= slms_pkg::DEAD_ZONE_RST;
            r_eye_ovr   <= 1'b0;
            r_eye_pat   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                slms_pkg::REG_DEAD_ZONE:   r_dead_zone <= i_cfg_data;
                slms_pkg::REG_EYE_OVR_ON:  r_eye_ovr   <= i_cfg_data[0];
                slms_pkg::REG_EYE_PATTERN: r_eye_pat   <= i_cfg_data[slms_pkg::ROW_W-1:0];
                default: begin
                    r_eye_ovr <= r_eye_ovr;
                end
            endcase
        end
    end

    // state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_face      <= '0;
            r_batch     <= '0;
            r_sum       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_col   <= n_col;
                r_face  <= n_face;
                r_batch <= n_batch;
                r_sum   <= n_sum;
            end
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1.command <= i_in.command;
            r_s1.sample  <= i_in.sample;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    `SLMS_ASSERT(a_batch_cleared, i_clk, i_rst_n, (r_out_valid && r_out.level_updated) |-> (r_batch == '0 && r_sum == '0))
    `SLMS_ASSERT(a_face_in_range, i_clk, i_rst_n, r_face <= FACE_LAST)
    `SLMS_ASSERT(a_tick_steps, i_clk, i_rst_n, (s1_adv && r_s1.command == slms_pkg::CMD_TICK) |=> (r_col == $past(r_col) + 1'b1))
    `SLMS_ASSERT(a_col_tracks, i_clk, i_rst_n, r_out_valid |-> (r_out.column == r_col && r_out.face_level == slms_pkg::LEVEL_W'(r_face)))

endmodule

`default_nettype wire

[sim/sound_level_led_matrix_scanner_test.sv]
`timescale 1ns / 1ps

// Self-checking bench for the LED face scanner.
// Ticks and audio samples go in through the input channel. Each accepted word
// is run through a local model of the scanner, and the model's result word is
// queued. Each result word that leaves the block is compared with the oldest
// queued word. Settings change only between phases, once the pipe has drained.
module sound_level_led_matrix_scanner_test;

    localparam int CLK_HALF    = 4;
    localparam int RST_CYCLES  = 10;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;   // long output stall for back-pressure
    localparam int MID_LEVEL   = 512;
    localparam int SUM_CEIL    = 8191;  // 13-bit accumulator saturates here
    localparam int LAST_FACE   = 5;

    // Bitmaps as the display should show them: face, then column.
    localparam logic [4:0] FACE_ROWS [6][8] = '{
        '{5'h00, 5'h0A, 5'h00, 5'h0E, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h0A, 5'h00, 5'h0E, 5'h0E, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h0A, 5'h00, 5'h0E, 5'h11, 5'h0E, 5'h00, 5'h00},
        '{5'h00, 5'h0A, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h0E, 5'h00},
        '{5'h00, 5'h0A, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h00, 5'h1B, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [slms_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [slms_pkg::CFG_DATA_W-1:0] i_cfg_data;

    slms_in_if  in_if ();
    slms_out_if out_if ();

    sound_level_led_matrix_scanner u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Words waiting to be offered, and result words the block still owes us.
    slms_pkg::t_in_word  pending_words [$];
    slms_pkg::t_out_word scan_words_due [$];

    // Model copy of the settings; starts at the reset values.
    logic [8:0] dead_zone_cfg = slms_pkg::DEAD_ZONE_RST;
    logic       eye_on_cfg    = 1'b0;
    logic [4:0] eye_pat_cfg   = 5'd0;

    // Model copy of the scanner state.
    logic [2:0] scan_col  = 3'd0;
    logic [2:0] face_sel  = 3'd0;
    int         batch_cnt = 0;
    int         loud_sum  = 0;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_left      = 0;
    bit  in_taken       = 1'b0;
    int  fail_count     = 0;
    int  cycles         = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Advances the model by one word and returns the result word it owes.
    function automatic slms_pkg::t_out_word next_scan_word(slms_pkg::t_in_word w);
        slms_pkg::t_out_word r;
        int hi;
        int lo;
        int gap;
        int lvl;
        int face;
        logic [4:0] lit;
        r.level_updated = 1'b0;
        if (w.command == slms_pkg::CMD_TICK) begin
            scan_col = scan_col + 3'd1;
        end else begin
            hi = MID_LEVEL + int'(dead_zone_cfg);
            lo = MID_LEVEL - int'(dead_zone_cfg);
            if (int'(w.sample) > hi) begin
                gap = int'(w.sample) - hi;
            end else if (int'(w.sample) < lo) begin
                gap = lo - int'(w.sample);
            end else begin
                gap = 0;
            end
            loud_sum = loud_sum + gap;
            if (loud_sum > SUM_CEIL) begin
                loud_sum = SUM_CEIL;
            end
            batch_cnt++;
            if (batch_cnt >= slms_pkg::SAMPLES_PER_BATCH) begin
                lvl = loud_sum / slms_pkg::SAMPLES_PER_BATCH / slms_pkg::LEVEL_SCALE;
                if (lvl >= slms_pkg::NUM_FACES) begin
                    lvl = slms_pkg::NUM_FACES - 1;
                end
                face_sel        = lvl[2:0];
                loud_sum        = 0;
                batch_cnt       = 0;
                r.level_updated = 1'b1;
            end
        end
        // faces past the stored six show the last bitmap
        face = (int'(face_sel) > LAST_FACE) ? LAST_FACE : int'(face_sel);
        if (scan_col == slms_pkg::EYE_COL && eye_on_cfg) begin
            lit = eye_pat_cfg;
        end else begin
            lit = FACE_ROWS[face][scan_col];
        end
        r.column     = scan_col;
        r.row_drive  = ~lit;           // rows are active low
        r.face_level = face_sel;
        return r;
    endfunction

    // Input driver: holds a word until taken, then offers the next or idles.
    always @(negedge i_clk) begin : feed_driver
        slms_pkg::t_in_word w;
        if (!in_if.valid || in_taken) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                w = pending_words.pop_front();
                in_if.valid   <= 1'b1;
                in_if.command <= w.command;
                in_if.sample  <= w.sample;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Output side: random stalls, plus the long hold-off when one is armed.
    always @(negedge i_clk) begin : drain_driver
        if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on input handshakes, check on output handshakes.
    always @(posedge i_clk) begin : scan_monitor
        slms_pkg::t_in_word  w;
        slms_pkg::t_out_word got;
        slms_pkg::t_out_word want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                w.command = in_if.command;
                w.sample  = in_if.sample;
                scan_words_due.push_back(next_scan_word(w));
                in_taken = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                got.column        = out_if.column;
                got.row_drive     = out_if.row_drive;
                got.face_level    = out_if.face_level;
                got.level_updated = out_if.level_updated;
                if (scan_words_due.size() == 0) begin
                    $error("result word with nothing outstanding: column %0d row_drive %0h",
                           got.column, got.row_drive);
                    fail_count++;
                end else begin
                    want = scan_words_due.pop_front();
                    if (got.column !== want.column) begin
                        $error("column: expected %0d, got %0d", want.column, got.column);
                        fail_count++;
                    end
                    if (got.row_drive !== want.row_drive) begin
                        $error("row_drive: expected %0h, got %0h",
                               want.row_drive, got.row_drive);
                        fail_count++;
                    end
                    if (got.face_level !== want.face_level) begin
                        $error("face_level: expected %0d, got %0d",
                               want.face_level, got.face_level);
                        fail_count++;
                    end
                    if (got.level_updated !== want.level_updated) begin
                        $error("level_updated: expected %0d, got %0d",
                               want.level_updated, got.level_updated);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_word(input logic [0:0] cmd, input int s);
        slms_pkg::t_in_word w;
        w.command = cmd;
        w.sample  = s[9:0];
        pending_words.push_back(w);
    endtask

    // Random traffic: mostly samples grouped into batches of similar loudness
    // so every face level shows up, with ticks sprinkled in and some raw noise.
    task automatic queue_random(input int n);
        int amp;
        int dev;
        int s;
        int n_smp;
        n_smp = 0;
        amp   = 0;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 30) begin
                // sample field is don't-care on a tick; fill it anyway
                push_word(slms_pkg::CMD_TICK, $urandom_range(1023));
            end else begin
                if (n_smp % slms_pkg::SAMPLES_PER_BATCH == 0) begin
                    amp = ($urandom_range(3) == 0) ? 511 : $urandom_range(180);
                end
                n_smp++;
                if ($urandom_range(9) == 0) begin
                    s = $urandom_range(1023);
                end else begin
                    dev = $urandom_range(amp);
                    s   = $urandom_range(1) ? MID_LEVEL + dev : MID_LEVEL - dev;
                    if (s > 1023) s = 1023;
                    if (s < 0)    s = 0;
                end
                push_word(slms_pkg::CMD_SAMPLE, s);
            end
        end
    endtask

    // Wait at a falling edge until every word is in and every result is out.
    task automatic drain_pipe();
        while (pending_words.size() != 0 || in_if.valid || scan_words_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);  // two-stage pipe, plus margin
    endtask

    // Writes all three registers one after another; called at a falling edge.
    task automatic apply_settings(input logic [8:0] dz, input bit eye_on,
                                  input logic [4:0] pat);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= slms_pkg::REG_DEAD_ZONE;
        i_cfg_data <= dz;
        @(negedge i_clk);
        i_cfg_idx  <= slms_pkg::REG_EYE_OVR_ON;
        i_cfg_data <= {8'd0, eye_on};
        @(negedge i_clk);
        i_cfg_idx  <= slms_pkg::REG_EYE_PATTERN;
        i_cfg_data <= {4'd0, pat};
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        dead_zone_cfg = dz;
        eye_on_cfg    = eye_on;
        eye_pat_cfg   = pat;
        @(negedge i_clk);
    endtask

    initial begin : sequencer
        // known levels on every input from time zero
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = slms_pkg::REG_DEAD_ZONE;
        i_cfg_data    = '0;
        in_if.valid   = 1'b0;
        in_if.command = slms_pkg::CMD_TICK;
        in_if.sample  = '0;
        out_if.ready  = 1'b0;

        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words at reset settings (dead zone 12, no eye override).
        // Nine ticks walk every column, wrapping through 0 back to 1.
        for (int k = 0; k < 9; k++) push_word(slms_pkg::CMD_TICK, 0);
        // Loud batch: both rails, mid-scale, both zone edges and one past each.
        // Sum is well over the top face, so the level clamps.
        push_word(slms_pkg::CMD_SAMPLE, 0);
        push_word(slms_pkg::CMD_SAMPLE, 1023);
        push_word(slms_pkg::CMD_SAMPLE, 512);
        push_word(slms_pkg::CMD_SAMPLE, 500);
        push_word(slms_pkg::CMD_SAMPLE, 499);
        push_word(slms_pkg::CMD_SAMPLE, 524);
        push_word(slms_pkg::CMD_SAMPLE, 525);
        push_word(slms_pkg::CMD_SAMPLE, 511);
        // Quiet batch brings the face back to level 0; accumulator must be clear.
        for (int k = 0; k < 8; k++) push_word(slms_pkg::CMD_SAMPLE, 506 + k);
        drain_pipe();

        // No dead zone, eye override on with all rows lit: widest distances.
        apply_settings(9'd0, 1'b1, 5'h1F);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random(220);
        drain_pipe();

        // Widest dead zone: only a zero sample gives any distance.
        apply_settings(9'd511, 1'b1, 5'h00);
        send_idle_pct  = 56;
        recv_stall_pct = 0;
        queue_random(180);
        drain_pipe();

        apply_settings(9'($urandom_range(200)), 1'b0, 5'($urandom_range(31)));
        send_idle_pct  = 0;
        recv_stall_pct = 56;
        queue_random(220);
        drain_pipe();

        apply_settings(slms_pkg::DEAD_ZONE_RST, 1'b1, 5'($urandom_range(31)));
        send_idle_pct  = 34;
        recv_stall_pct = 34;
        queue_random(220);
        drain_pipe();

        // Back-pressure: output held off for a long stretch while words keep
        // coming, so the pipe fills and input ready must drop.
        apply_settings(9'($urandom_range(60)), 1'($urandom_range(1)), 5'($urandom_range(31)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        queue_random(220);
        drain_pipe();

        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/slms_pkg.sv
sv/slms_in_if.sv
sv/slms_out_if.sv
sv/sound_level_led_matrix_scanner.sv
sim/sound_level_led_matrix_scanner_test.sv
